@@ rtl/core/sarp_pkg.sv @@
`default_nettype none

package sarp_pkg;

  localparam int BYTE_W   = 8;
  localparam int ACC_W    = 20;
  localparam int ANGLE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SIGN = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_COLON = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_SEP   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NO_TERM  = 3'd4;

  // reply characters
  localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;

  // full circle is 86400 s (RA) or 1296000 arcsec (Dec); both hold 2^7,
  // so the scale becomes acc * 2^25 / odd divisor
  localparam int ACC_SCALE    = 25;
  localparam int DIV_W        = 14;
  localparam int RA_DIV       = 675;
  localparam int DEC_DIV      = 10125;
  localparam int RECIP_SHIFT  = ACC_W;
  localparam int RECIP_W      = 36;
  localparam int PROD_W       = ACC_W + RECIP_W;
  // remainder lies below twice the largest divisor
  localparam int REM_W        = 15;

  localparam logic [RECIP_W-1:0] RECIP_RA =
    RECIP_W'((64'd1 << (ACC_SCALE + RECIP_SHIFT)) / 64'(RA_DIV));
  localparam logic [RECIP_W-1:0] RECIP_DEC =
    RECIP_W'((64'd1 << (ACC_SCALE + RECIP_SHIFT)) / 64'(DEC_DIV));

endpackage

`default_nettype wire

@@ rtl/core/sarp_if.sv @@
`default_nettype none

interface sarp_in_if;
  import sarp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              reply_kind;

  modport source (output valid, rx_byte, reply_kind, input ready);
  modport sink   (input valid, rx_byte, reply_kind, output ready);
endinterface

interface sarp_out_if;
  import sarp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ANGLE_W-1:0]  angle_word;
  logic                has_seconds;
  logic                was_dec;

  modport source (output valid, status, angle_word, has_seconds, was_dec, input ready);
  modport sink   (input valid, status, angle_word, has_seconds, was_dec, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sexagesimal_angle_reply_parser.sv @@
`default_nettype none

// Sexagesimal RA/Dec reply parser. Reply bytes arrive one per transfer on in_i, with
// reply_kind (0 RA, 1 Dec) sampled on the first byte of a reply; one leading '#' is
// skipped. RA is HH:MM:SS# or HH:MM.T#, Dec is sign DD <any byte> MM then '#' or
// :SS#; digit bytes contribute their low nibble unchecked. The terminator or a syntax
// error yields one transfer on out_o: the angle scaled so a full circle is 2^32
// (two's complement for negative Dec), the long-format flag and the reply kind, or an
// error status with a zero angle, after which parsing restarts. A byte is taken every
// cycle while in_i.ready is high; a result reaches out_o through the reply register
// loaded by the transfer of its last byte, the reciprocal multiply stage, the
// remainder stage and the output register. Each of the four stages holds one
// result, so a stalled output stops bytes only once all four stages are full.
module sexagesimal_angle_reply_parser (
  input  wire        clk_i,
  input  wire        rst_ni,
  sarp_in_if.sink    in_i,
  sarp_out_if.source out_o
);
  import sarp_pkg::*;

  // reply position: idle, leading hash seen, then data byte index + 2
  localparam logic [POS_W-1:0] POS_IDLE = 4'd0;
  localparam logic [POS_W-1:0] POS_HASH = 4'd1;
  localparam logic [POS_W-1:0] POS_LAST = 4'd10;

  // RA data bytes
  localparam logic [POS_W-1:0] RA_HOUR_HI  = 4'd0;
  localparam logic [POS_W-1:0] RA_HOUR_LO  = 4'd1;
  localparam logic [POS_W-1:0] RA_COLON    = 4'd2;
  localparam logic [POS_W-1:0] RA_MIN_HI   = 4'd3;
  localparam logic [POS_W-1:0] RA_MIN_LO   = 4'd4;
  localparam logic [POS_W-1:0] RA_SEP      = 4'd5;
  localparam logic [POS_W-1:0] RA_FIELD_HI = 4'd6;
  localparam logic [POS_W-1:0] RA_FIELD_LO = 4'd7;
  localparam logic [POS_W-1:0] RA_TERM     = 4'd8;

  // Dec data bytes
  localparam logic [POS_W-1:0] DEC_SIGN     = 4'd0;
  localparam logic [POS_W-1:0] DEC_DEG_HI   = 4'd1;
  localparam logic [POS_W-1:0] DEC_DEG_LO   = 4'd2;
  localparam logic [POS_W-1:0] DEC_DEG_MARK = 4'd3;
  localparam logic [POS_W-1:0] DEC_MIN_HI   = 4'd4;
  localparam logic [POS_W-1:0] DEC_MIN_LO   = 4'd5;
  localparam logic [POS_W-1:0] DEC_SEP      = 4'd6;
  localparam logic [POS_W-1:0] DEC_SEC_HI   = 4'd7;
  localparam logic [POS_W-1:0] DEC_SEC_LO   = 4'd8;
  localparam logic [POS_W-1:0] DEC_TERM     = 4'd9;

  // ---------------------------------------------------------------------------
  // elastic stage handshake: a stage may load when empty or when it drains
  // ---------------------------------------------------------------------------
  logic a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic a_free, b_free, c_free, out_free;
  logic in_fire;

  assign out_free = !out_valid_q || out_o.ready;
  assign c_free   = !c_valid_q || out_free;
  assign b_free   = !b_valid_q || c_free;
  assign a_free   = !a_valid_q || b_free;

  assign in_i.ready = a_free;
  assign in_fire    = in_i.valid && a_free;

  // ---------------------------------------------------------------------------
  // byte parser
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] pos_q, pos_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic             kind_q, kind_d;
  logic             short_q, short_d;

  logic [POS_W-1:0]    pos_eff, step;
  logic                kind_cur, neg_cur, short_cur, skip_hash;
  logic [ACC_W-1:0]    acc_cur, nib, acc_mac6, acc_mac10, acc_x6, acc_x60;
  logic                emit;
  logic [STATUS_W-1:0] res_status;
  logic [ACC_W-1:0]    res_acc;
  logic                res_long;
  logic [BYTE_W-1:0]   rx;

  assign rx  = in_i.rx_byte;
  assign nib = ACC_W'(rx[3:0]);

  always_comb begin
    // a position the parser never reaches starts a new reply
    pos_eff   = (pos_q > POS_LAST) ? POS_IDLE : pos_q;
    kind_cur  = kind_q;
    acc_cur   = acc_q;
    neg_cur   = neg_q;
    short_cur = short_q;
    skip_hash = 1'b0;
    step      = pos_eff - 4'd1;
    if (pos_eff == POS_IDLE) begin
      kind_cur  = in_i.reply_kind;
      acc_cur   = '0;
      neg_cur   = 1'b0;
      short_cur = 1'b0;
      skip_hash = (rx == CHAR_HASH);
      step      = '0;
    end
  end

  // narrow constant multiplies, shift-and-add in practice
  assign acc_mac6  = ACC_W'(acc_cur * 20'd6 + nib);
  assign acc_mac10 = ACC_W'(acc_cur * 20'd10 + nib);
  assign acc_x6    = ACC_W'(acc_cur * 20'd6);
  assign acc_x60   = ACC_W'(acc_cur * 20'd60);

  always_comb begin
    pos_d      = pos_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    kind_d     = kind_q;
    short_d    = short_q;
    emit       = 1'b0;
    res_status = STATUS_OK;
    res_acc    = '0;
    res_long   = 1'b0;

    if (in_fire) begin
      kind_d  = kind_cur;
      acc_d   = acc_cur;
      neg_d   = neg_cur;
      short_d = short_cur;

      if (skip_hash) begin
        pos_d = POS_HASH;
      end else begin
        pos_d = step + 4'd2;
        if (!kind_cur) begin
          case (step)
            RA_HOUR_HI: acc_d = nib;
            RA_HOUR_LO: acc_d = acc_mac10;
            RA_COLON: begin
              if (rx != CHAR_COLON) begin
                emit       = 1'b1;
                res_status = STATUS_NO_COLON;
              end
            end
            RA_MIN_HI: acc_d = acc_mac6;
            RA_MIN_LO: acc_d = acc_mac10;
            RA_SEP: begin
              if (rx == CHAR_COLON) begin
                short_d = 1'b0;
              end else if (rx == CHAR_DOT) begin
                short_d = 1'b1;
              end else begin
                emit       = 1'b1;
                res_status = STATUS_NO_SEP;
              end
            end
            RA_FIELD_HI: acc_d = short_cur ? acc_mac10 : acc_mac6;
            RA_FIELD_LO: begin
              if (!short_cur) begin
                acc_d = acc_mac10;
              end else if (rx != CHAR_HASH) begin
                emit       = 1'b1;
                res_status = STATUS_NO_TERM;
              end else begin
                // tenths of a minute: six seconds each
                acc_d   = acc_x6;
                emit    = 1'b1;
                res_acc = acc_x6;
              end
            end
            RA_TERM: begin
              if (short_cur) begin
                pos_d = POS_IDLE;
              end else if (rx != CHAR_HASH) begin
                emit       = 1'b1;
                res_status = STATUS_NO_TERM;
              end else begin
                emit     = 1'b1;
                res_acc  = acc_cur;
                res_long = 1'b1;
              end
            end
            default: pos_d = POS_IDLE;
          endcase
        end else begin
          case (step)
            DEC_SIGN: begin
              if (rx == CHAR_PLUS) begin
                neg_d = 1'b0;
              end else if (rx == CHAR_MINUS) begin
                neg_d = 1'b1;
              end else begin
                emit       = 1'b1;
                res_status = STATUS_BAD_SIGN;
              end
            end
            DEC_DEG_HI:   acc_d = nib;
            DEC_DEG_LO:   acc_d = acc_mac10;
            DEC_DEG_MARK: acc_d = acc_cur;   // degree mark, any byte tolerated
            DEC_MIN_HI:   acc_d = acc_mac6;
            DEC_MIN_LO:   acc_d = acc_mac10;
            DEC_SEP: begin
              if (rx == CHAR_HASH) begin
                // minutes only: scale to arcseconds
                short_d = 1'b1;
                acc_d   = acc_x60;
                emit    = 1'b1;
                res_acc = acc_x60;
              end else if (rx == CHAR_COLON) begin
                short_d = 1'b0;
              end else begin
                emit       = 1'b1;
                res_status = STATUS_NO_SEP;
              end
            end
            DEC_SEC_HI: acc_d = acc_mac6;
            DEC_SEC_LO: acc_d = acc_mac10;
            DEC_TERM: begin
              emit = 1'b1;
              if (rx != CHAR_HASH) begin
                res_status = STATUS_NO_TERM;
              end else begin
                res_acc  = acc_cur;
                res_long = 1'b1;
              end
            end
            default: pos_d = POS_IDLE;
          endcase
        end
        if (emit) begin
          pos_d = POS_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_IDLE;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      kind_q  <= 1'b0;
      short_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      kind_q  <= kind_d;
      short_q <= short_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: finished reply
  // ---------------------------------------------------------------------------
  logic [STATUS_W-1:0] a_status_q;
  logic [ACC_W-1:0]    a_acc_q;
  logic                a_kind_q, a_neg_q, a_long_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      a_status_q <= res_status;
      a_acc_q    <= res_acc;
      a_kind_q   <= kind_cur;
      a_neg_q    <= neg_cur;
      a_long_q   <= res_long;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: quotient estimate acc * floor(2^45 / div) >> 20, low or exact
  // by one; only the low 32 bits of the quotient matter
  // ---------------------------------------------------------------------------
  logic [RECIP_W-1:0]  recip_a;
  logic [PROD_W-1:0]   prod_a;
  logic [STATUS_W-1:0] b_status_q;
  logic [ANGLE_W-1:0]  b_q0_q;
  logic                b_kind_q, b_neg_q, b_long_q;

  assign recip_a = a_kind_q ? RECIP_DEC : RECIP_RA;
  assign prod_a  = a_acc_q * recip_a;

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_free) begin
      b_status_q <= a_status_q;
      b_q0_q     <= prod_a[RECIP_SHIFT +: ANGLE_W];
      b_kind_q   <= a_kind_q;
      b_neg_q    <= a_neg_q;
      b_long_q   <= a_long_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: remainder acc*2^25 - q0*div, known to lie in [0, 2*div), so
  // its low bits are enough and the acc*2^25 term vanishes
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0]       div_b;
  logic [REM_W+DIV_W-1:0] rem_prod_b;
  logic [STATUS_W-1:0]    c_status_q;
  logic [ANGLE_W-1:0]     c_q0_q;
  logic [REM_W-1:0]       c_rem_q;
  logic                   c_kind_q, c_neg_q, c_long_q;

  assign div_b      = b_kind_q ? DIV_W'(DEC_DIV) : DIV_W'(RA_DIV);
  assign rem_prod_b = b_q0_q[REM_W-1:0] * div_b;

  always_ff @(posedge clk_i) begin
    if (b_valid_q && c_free) begin
      c_status_q <= b_status_q;
      c_q0_q     <= b_q0_q;
      c_rem_q    <= REM_W'(15'd0 - rem_prod_b[REM_W-1:0]);
      c_kind_q   <= b_kind_q;
      c_neg_q    <= b_neg_q;
      c_long_q   <= b_long_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: correct the estimate, negate with ceiling for negative Dec
  // ---------------------------------------------------------------------------
  logic [REM_W-1:0]    div_c;
  logic                bump_c, rem_nz_c;
  logic [ANGLE_W-1:0]  quot_c, angle_c;
  logic [STATUS_W-1:0] out_status_q;
  logic [ANGLE_W-1:0]  out_angle_q;
  logic                out_long_q, out_dec_q;

  assign div_c    = c_kind_q ? REM_W'(DEC_DIV) : REM_W'(RA_DIV);
  assign bump_c   = (c_rem_q >= div_c);
  assign rem_nz_c = bump_c ? (c_rem_q != div_c) : (c_rem_q != '0);
  assign quot_c   = c_q0_q + ANGLE_W'(bump_c);

  always_comb begin
    if (c_status_q != STATUS_OK) begin
      angle_c = '0;
    end else if (c_kind_q && c_neg_q) begin
      angle_c = ANGLE_W'(32'd0 - quot_c - ANGLE_W'(rem_nz_c));
    end else begin
      angle_c = quot_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid_q && out_free) begin
      out_status_q <= c_status_q;
      out_angle_q  <= angle_c;
      out_long_q   <= c_long_q;
      out_dec_q    <= c_kind_q;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_q <= in_fire && emit;
      end
      if (b_free) begin
        b_valid_q <= a_valid_q;
      end
      if (c_free) begin
        c_valid_q <= b_valid_q;
      end
      if (out_free) begin
        out_valid_q <= c_valid_q;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.angle_word  = out_angle_q;
  assign out_o.has_seconds = out_long_q;
  assign out_o.was_dec     = out_dec_q;

endmodule

`default_nettype wire

@@ rtl/core/sarp_checker.sv @@
`default_nettype none

module sarp_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_ready_i,
  input wire                          out_valid_i,
  input wire                          out_ready_i,
  input wire [sarp_pkg::STATUS_W-1:0] status_i,
  input wire [sarp_pkg::ANGLE_W-1:0]  angle_i,
  input wire                          long_i,
  input wire                          was_dec_i
);
  import sarp_pkg::*;

  // a result waiting for transfer keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(angle_i)
      && $stable(long_i) && $stable(was_dec_i))
    else $error("stalled result changed");

  // an error result carries no angle and no long flag
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != STATUS_OK |-> angle_i == '0 && !long_i)
    else $error("error result with angle or long flag");

  // a sign error only comes from a declination reply
  a_sign_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_BAD_SIGN |-> was_dec_i)
    else $error("bad sign reported for right ascension");

  // a missing colon only comes from a right ascension reply
  a_colon_ra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_NO_COLON |-> !was_dec_i)
    else $error("colon error reported for declination");

  // with the output empty the whole pipeline drains, so bytes are taken
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind sexagesimal_angle_reply_parser sarp_checker u_sarp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .angle_i     (out_o.angle_word),
  .long_i      (out_o.has_seconds),
  .was_dec_i   (out_o.was_dec)
);

`default_nettype wire
